>>> design/brsp_pkg.sv
// Shared types, codes and helper functions of the byte range header parser.
package brsp_pkg;

  localparam logic [7:0] CharEquals = 8'h3D;
  localparam logic [7:0] CharDash   = 8'h2D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;

  typedef enum logic [2:0] {
    PH_SEEK         = 3'd0,
    PH_IDLE         = 3'd1,
    PH_START        = 3'd2,
    PH_DASH         = 3'd3,
    PH_END          = 3'd4,
    PH_SUFFIX_FIRST = 3'd5,
    PH_SUFFIX       = 3'd6
  } phase_e;

  typedef enum logic {
    KIND_RANGE   = 1'b0,
    KIND_VERDICT = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } brsp_in_t;

  typedef struct packed {
    logic        item_kind;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic        parse_error;
    logic [4:0]  range_count;
    logic        last_result;
  } brsp_out_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic [31:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CharZero;
    return {28'd0, d[3:0]};
  endfunction

  // v*10 + digit, saturating; bit 32 flags the overflow
  function automatic logic [32:0] accumulate(input logic [31:0] v, input logic [7:0] c);
    logic [35:0] r;
    r = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {4'd0, digit_val(c)};
    if (r[35:32] != 4'd0) begin
      return {1'b1, 32'hFFFF_FFFF};
    end
    return {1'b0, r[31:0]};
  endfunction

  function automatic logic [31:0] suffix_start(input logic [31:0] len,
                                               input logic [31:0] size);
    return (len >= size) ? 32'd0 : size - len;
  endfunction

endpackage

>>> design/byte_range_spec_parser.sv
// Byte range header parser: one-pass byte decoder feeding a small result queue.
// A result is written into the queue register when its byte is accepted; out_data_o shows the queue head.
// Throughput: one byte per cycle; in_ready_o drops only when the 4-beat result
//   queue lacks room for the two results one byte can cause (range + verdict).
// Reset: parse state clears to the seek-equals phase, resource size to 1, queue empty.
// After each final byte the parser returns to its reset phase; size is kept.
module byte_range_spec_parser import brsp_pkg::*; #(
  parameter int MAX_RANGES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  brsp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output brsp_out_t out_data_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [31:0] size_q;
  phase_e      phase_q, phase_d;
  logic [31:0] first_q, first_d;
  logic [31:0] second_q, second_d;
  logic        err_q, err_d;
  logic [4:0]  found_q, found_d;

  brsp_out_t   fifo_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q, fill_d;

  logic in_fire, out_fire;
  logic rng_v, verdict_v;
  logic [31:0] rng_s, rng_e;
  brsp_out_t item0, item1;
  logic [1:0] n_push;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_comb begin
    phase_e      ph;
    logic [31:0] f, s, size_end, ws, we;
    logic        e, want, btw;
    logic [4:0]  c;
    logic [7:0]  ch;
    logic [32:0] acc;

    ch       = in_data_i.char_byte;
    ph       = phase_q;
    f        = first_q;
    s        = second_q;
    e        = err_q;
    c        = found_q;
    size_end = size_q - 32'd1;
    want     = 1'b0;
    btw      = 1'b0;
    ws       = 32'd0;
    we       = 32'd0;
    acc      = 33'd0;
    rng_v    = 1'b0;
    rng_s    = 32'd0;
    rng_e    = 32'd0;

    unique case (ph)
      PH_SEEK: begin
        if (ch == CharEquals) ph = PH_IDLE;
      end
      PH_START: begin
        if (is_digit(ch)) begin
          acc = accumulate(f, ch);
          f   = acc[31:0];
          e   = e | acc[32];
        end else begin
          if (ch != CharDash) e = 1'b1;  // consumed as the dash
          ph = PH_DASH;
        end
      end
      PH_DASH: begin
        if (is_digit(ch)) begin
          s  = digit_val(ch);
          ph = PH_END;
        end else begin
          want = 1'b1; ws = f; we = size_end; btw = 1'b1;
        end
      end
      PH_END: begin
        if (is_digit(ch)) begin
          acc = accumulate(s, ch);
          s   = acc[31:0];
          e   = e | acc[32];
        end else begin
          want = 1'b1; ws = f; we = s; btw = 1'b1;
        end
      end
      PH_SUFFIX_FIRST: begin
        if (is_digit(ch)) begin
          f  = digit_val(ch);
          ph = PH_SUFFIX;
        end else begin
          e    = 1'b1;  // empty suffix
          want = 1'b1; ws = suffix_start(32'd0, size_q); we = size_end; btw = 1'b1;
        end
      end
      PH_SUFFIX: begin
        if (is_digit(ch)) begin
          acc = accumulate(f, ch);
          f   = acc[31:0];
          e   = e | acc[32];
        end else begin
          want = 1'b1; ws = suffix_start(f, size_q); we = size_end; btw = 1'b1;
        end
      end
      default: begin
        btw = 1'b1;
      end
    endcase

    if (want) begin
      if (int'(c) >= MAX_RANGES) begin
        e = 1'b1;
      end else begin
        rng_v = 1'b1; rng_s = ws; rng_e = we;
        c = c + 5'd1;
      end
    end

    // terminating byte is reparsed as a between-ranges byte
    if (btw) begin
      ph = PH_IDLE;
      if (is_digit(ch)) begin
        f  = digit_val(ch);
        ph = PH_START;
      end else if (ch == CharDash) begin
        f  = 32'd0;
        ph = PH_SUFFIX_FIRST;
      end
    end

    // end of header: close what is pending, at most one range overall per byte
    verdict_v = in_data_i.last_byte;
    if (in_data_i.last_byte) begin
      want = 1'b0;
      unique case (ph)
        PH_SEEK:         e = 1'b1;
        PH_START:        begin e = 1'b1; want = 1'b1; ws = f; we = size_end; end
        PH_DASH:         begin want = 1'b1; ws = f; we = size_end; end
        PH_END:          begin want = 1'b1; ws = f; we = s; end
        PH_SUFFIX_FIRST: e = 1'b1;
        PH_SUFFIX:       begin want = 1'b1; ws = suffix_start(f, size_q); we = size_end; end
        default:         ;
      endcase
      if (want) begin
        if (int'(c) >= MAX_RANGES) begin
          e = 1'b1;
        end else begin
          rng_v = 1'b1; rng_s = ws; rng_e = we;
          c = c + 5'd1;
        end
      end
    end

    item0 = '0;
    item1 = '0;
    if (rng_v) begin
      item0.item_kind   = KIND_RANGE;
      item0.range_start = rng_s;
      item0.range_end   = rng_e;
    end
    if (verdict_v) begin
      item1.item_kind   = KIND_VERDICT;
      item1.parse_error = e;
      item1.range_count = c;
      item1.last_result = 1'b1;
      if (!rng_v) item0 = item1;
      ph = PH_SEEK; f = 32'd0; s = 32'd0; e = 1'b0; c = 5'd0;
    end
    n_push = {1'b0, rng_v} + {1'b0, verdict_v};

    phase_d  = ph;
    first_d  = f;
    second_d = s;
    err_d    = e;
    found_d  = c;
  end

  assign fill_d = fill_q + (in_fire ? CntW'(n_push) : CntW'(0)) - CntW'(out_fire);

  assign in_ready_o  = (fill_q <= CntW'(Depth - 2));
  assign out_valid_o = (fill_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= 32'd1;
      phase_q  <= PH_SEEK;
      first_q  <= 32'd0;
      second_q <= 32'd0;
      err_q    <= 1'b0;
      found_q  <= 5'd0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (in_fire) begin
        phase_q  <= phase_d;
        first_q  <= first_d;
        second_q <= second_d;
        err_q    <= err_d;
        found_q  <= found_d;
        wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      end
      if (out_fire) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (n_push != 2'd0)) fifo_q[wr_ptr_q] <= item0;
    if (in_fire && (n_push == 2'd2)) fifo_q[wr_ptr_q + PtrW'(1)] <= item1;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(Depth))
    else $error("result queue overfilled");

  a_verdict_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.last_byte |=> fill_q != '0)
    else $error("final byte left no verdict beat");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.last_byte |=> phase_q == PH_SEEK && found_q == 5'd0 && !err_q)
    else $error("parser not cleared after final byte");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |=> rd_ptr_q == $past(rd_ptr_q) + PtrW'(1))
    else $error("read pointer did not advance on output beat");

endmodule
